// ===== rtl/hbrp_pkg.sv =====
package hbrp_pkg;

  localparam int VALUE_BITS = 63;
  localparam int SIZE_BITS  = 64;
  localparam int OUT_BITS   = 63;
  localparam int ACC_BITS   = VALUE_BITS + 4;

  localparam logic [2:0] PREFIX_LEN = 3'd6;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] ST_MALFORMED = 2'd0;
  localparam logic [1:0] ST_UNSAT     = 2'd1;
  localparam logic [1:0] ST_OK        = 2'd2;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_PREFIX,
    PH_FIRST,
    PH_LAST
  } phase_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/http_byte_range_parser_top.sv =====
// Parses an HTTP Range header holding one byte range. Each input word carries one
// header character (tuser low) or an end-of-header marker (tuser high). Leading and
// trailing whitespace is skipped; the text must read "bytes=", an optional decimal
// first position, a dash and an optional decimal last position, with at least one
// position present. Positions saturate at 2^63-1. On end of header one result word
// gives the status (malformed, unsatisfiable, satisfiable) and, when satisfiable,
// the start and inclusive end resolved against resource_size (suffix form, open end,
// end clamped to size-1); the parser then starts over. resource_size resets to -1
// (unknown); the user must write it through cfg_wr_en/cfg_wr_data only while the
// block is idle, as the block itself does not enforce this. Rate: one word per clock
// while no end-of-header word is held back. A word is registered at the input, then
// the character is folded into the parse state (one multiply-by-ten accumulate) or
// the range is resolved (wide subtracts and compares), and the result sits in an
// output register that drives out_tvalid. An end-of-header word waits in the
// input register, holding in_tready low, until an earlier result word is taken.
module http_byte_range_parser_top
  import hbrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_BITS-1:0] cfg_wr_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // header_byte
  input  logic                 in_tuser,   // command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata   // range_status, range_start, range_end
);

  logic [SIZE_BITS-1:0]  size_r;
  logic                  in_valid_r;
  logic                  cmd_r;
  logic [7:0]            byte_r;

  phase_t                phase_r, phase_nxt;
  logic [2:0]            pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] first_r, first_nxt;
  logic [VALUE_BITS-1:0] last_r, last_nxt;
  logic                  first_seen_r, first_seen_nxt;
  logic                  last_seen_r, last_seen_nxt;
  logic                  failed_r, failed_nxt;
  logic                  trail_r, trail_nxt;

  logic                  out_valid_r;
  logic [1:0]            status_r, status_nxt;
  logic [OUT_BITS-1:0]   start_r, start_nxt;
  logic [OUT_BITS-1:0]   end_r, end_nxt;

  logic                  stage_go;
  logic                  is_ws;
  logic                  is_digit;
  phase_t                ph_eff;
  logic [2:0]            pos_eff;
  logic [VALUE_BITS-1:0] acc_in;
  logic [ACC_BITS-1:0]   acc_sum;
  logic [VALUE_BITS-1:0] acc_out;

  logic [SIZE_BITS-1:0]  first_w, last_w, size_m1, start_w, end_w;

  assign stage_go  = in_valid_r && (cmd_r == CMD_BYTE || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || stage_go;

  // multiply-by-ten accumulate with saturation
  assign is_ws    = (byte_r == CH_SPACE) || (byte_r >= CH_TAB && byte_r <= CH_CR);
  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign ph_eff   = (phase_r == PH_LEAD) ? PH_PREFIX : phase_r;
  assign pos_eff  = (phase_r == PH_LEAD) ? 3'd0 : pos_r;
  assign acc_in   = (ph_eff == PH_FIRST) ? first_r : last_r;
  assign acc_sum  = ({4'd0, acc_in} << 3) + ({4'd0, acc_in} << 1)
                  + ACC_BITS'(byte_r - CH_ZERO);
  assign acc_out  = (acc_sum[ACC_BITS-1:VALUE_BITS] != '0) ? {VALUE_BITS{1'b1}}
                  : acc_sum[VALUE_BITS-1:0];

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    first_seen_nxt = first_seen_r;
    last_seen_nxt  = last_seen_r;
    failed_nxt     = failed_r;
    trail_nxt      = trail_r;
    if (cmd_r == CMD_END) begin
      phase_nxt      = PH_LEAD;
      pos_nxt        = 3'd0;
      first_nxt      = '0;
      last_nxt       = '0;
      first_seen_nxt = 1'b0;
      last_seen_nxt  = 1'b0;
      failed_nxt     = 1'b0;
      trail_nxt      = 1'b0;
    end else if (failed_r) begin
    end else if (is_ws) begin
      if (phase_r != PH_LEAD) begin
        trail_nxt = 1'b1;
      end
    end else if (trail_r) begin
      failed_nxt = 1'b1;
    end else if (ph_eff == PH_PREFIX) begin
      phase_nxt = PH_PREFIX;
      if (byte_r == prefix_char(pos_eff)) begin
        pos_nxt = pos_eff + 3'd1;
        if (pos_eff + 3'd1 == PREFIX_LEN) begin
          phase_nxt = PH_FIRST;
        end
      end else begin
        failed_nxt = 1'b1;
      end
    end else if (is_digit) begin
      if (ph_eff == PH_FIRST) begin
        first_nxt      = acc_out;
        first_seen_nxt = 1'b1;
      end else begin
        last_nxt      = acc_out;
        last_seen_nxt = 1'b1;
      end
    end else if (byte_r == CH_DASH && ph_eff == PH_FIRST) begin
      phase_nxt = PH_LAST;
    end else begin
      failed_nxt = 1'b1;
    end
  end

  // range resolution
  assign first_w = SIZE_BITS'(first_r);
  assign last_w  = SIZE_BITS'(last_r);
  assign size_m1 = size_r - SIZE_BITS'(1);
  assign start_w = first_seen_r ? first_w
                 : ((last_w >= size_r) ? '0 : size_r - last_w);
  assign end_w   = (!first_seen_r || !last_seen_r || last_w >= size_r) ? size_m1 : last_w;

  always_comb begin
    status_nxt = ST_OK;
    if (failed_r || phase_r != PH_LAST || (!first_seen_r && !last_seen_r)) begin
      status_nxt = ST_MALFORMED;
    end else if (size_r[SIZE_BITS-1]) begin
      status_nxt = ST_UNSAT;
    end else if (!first_seen_r) begin
      if (last_w == '0 || size_r == '0) begin
        status_nxt = ST_UNSAT;
      end
    end else if (first_w >= size_r || (last_seen_r && last_w < first_w)) begin
      status_nxt = ST_UNSAT;
    end
    start_nxt = (status_nxt == ST_OK) ? start_w[OUT_BITS-1:0] : '0;
    end_nxt   = (status_nxt == ST_OK) ? end_w[OUT_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= '1;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_LEAD;
      pos_r        <= 3'd0;
      first_r      <= '0;
      last_r       <= '0;
      first_seen_r <= 1'b0;
      last_seen_r  <= 1'b0;
      failed_r     <= 1'b0;
      trail_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (stage_go) begin
        phase_r      <= phase_nxt;
        pos_r        <= pos_nxt;
        first_r      <= first_nxt;
        last_r       <= last_nxt;
        first_seen_r <= first_seen_nxt;
        last_seen_r  <= last_seen_nxt;
        failed_r     <= failed_nxt;
        trail_r      <= trail_nxt;
      end
      if (stage_go && cmd_r == CMD_END) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r  <= in_tuser;
      byte_r <= in_tdata;
    end
    if (stage_go && cmd_r == CMD_END) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {end_r, start_r, status_r};

  a_ok_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_OK |-> start_r <= end_r)
    else $error("satisfiable range with start past end");

  a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> start_r == '0 && end_r == '0)
    else $error("nonzero range on failed status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> status_r == ST_MALFORMED || status_r == ST_UNSAT || status_r == ST_OK)
    else $error("undefined status code");

  a_prefix_done: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIRST || phase_r == PH_LAST |-> pos_r == PREFIX_LEN)
    else $error("number phase without complete prefix");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    stage_go && cmd_r == CMD_END |=> phase_r == PH_LEAD && !failed_r && !trail_r)
    else $error("parse state not cleared after end of header");

endmodule

// ===== tb/sv/hbrp_range_checker.sv =====
`timescale 1ns / 1ps
module hbrp_range_checker
  import hbrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_BITS-1:0] cfg_wr_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,   // header_byte
  input  logic                 in_tuser,   // command
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [127:0]         out_tdata,  // range_status, range_start, range_end
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [62:0] lo;
    logic [62:0] hi;
  } byte_range_t;

  localparam logic [62:0] POS_MAX     = '1;
  localparam logic [47:0] PREFIX_WORD = "bytes=";

  logic signed [63:0] size_reg;
  phase_t             phase;
  logic [2:0]         prefix_pos;
  logic [62:0]        first_val;
  logic [62:0]        last_val;
  logic               first_seen;
  logic               last_seen;
  logic               bad;
  logic               trail_ws;
  byte_range_t        range_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function void clear_state();
    phase      = PH_LEAD;
    prefix_pos = '0;
    first_val  = '0;
    last_val   = '0;
    first_seen = 1'b0;
    last_seen  = 1'b0;
    bad        = 1'b0;
    trail_ws   = 1'b0;
  endfunction

  // decimal accumulate that sticks at the top value
  function automatic logic [62:0] add_digit(input logic [62:0] v, input logic [7:0] c);
    logic [63:0] d;
    logic [63:0] wide;
    d    = {56'd0, c - CH_ZERO};
    wide = {1'b0, v};
    if (wide > ({1'b0, POS_MAX} - d) / 64'd10) begin
      return POS_MAX;
    end
    wide = wide * 64'd10 + d;
    return wide[62:0];
  endfunction

  function void fold_char(input logic [7:0] c);
    if (bad) begin
      return;
    end
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      if (phase != PH_LEAD) begin
        trail_ws = 1'b1;
      end
      return;
    end
    if (trail_ws) begin
      bad = 1'b1;
      return;
    end
    if (phase == PH_LEAD) begin
      phase      = PH_PREFIX;
      prefix_pos = '0;
    end
    if (phase == PH_PREFIX) begin
      if (prefix_pos < PREFIX_LEN && c == PREFIX_WORD[47 - 8 * prefix_pos -: 8]) begin
        prefix_pos = prefix_pos + 3'd1;
        if (prefix_pos == PREFIX_LEN) begin
          phase = PH_FIRST;
        end
      end else begin
        bad = 1'b1;
      end
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (phase == PH_FIRST) begin
        first_val  = add_digit(first_val, c);
        first_seen = 1'b1;
      end else begin
        last_val  = add_digit(last_val, c);
        last_seen = 1'b1;
      end
      return;
    end
    if (c == CH_DASH && phase == PH_FIRST) begin
      phase = PH_LAST;
      return;
    end
    bad = 1'b1;
  endfunction

  function byte_range_t resolve_range();
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] k;
    byte_range_t        r;
    r = '0;
    r.status = ST_MALFORMED;
    if (bad || phase != PH_LAST || (!first_seen && !last_seen)) begin
      return r;
    end
    r.status = ST_UNSAT;
    if (size_reg < 0) begin
      return r;
    end
    if (!first_seen) begin
      k = {1'b0, last_val};
      if (k == 0 || size_reg == 0) begin
        return r;
      end
      lo = (k >= size_reg) ? 64'sd0 : size_reg - k;
      hi = size_reg - 1;
    end else begin
      lo = {1'b0, first_val};
      hi = last_seen ? {1'b0, last_val} : size_reg - 1;
      if (lo >= size_reg || hi < lo) begin
        return r;
      end
      if (hi >= size_reg) begin
        hi = size_reg - 1;
      end
    end
    r.status = ST_OK;
    r.lo     = lo[62:0];
    r.hi     = hi[62:0];
    return r;
  endfunction

  task report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task check_word(input logic [127:0] word);
    byte_range_t want;
    if (range_q.size() == 0) begin
      report("unexpected result word, status", {62'd0, word[1:0]}, 64'd0);
      return;
    end
    want = range_q.pop_front();
    if (word[1:0] !== want.status) begin
      report("range_status", {62'd0, word[1:0]}, {62'd0, want.status});
    end
    if (word[64:2] !== want.lo) begin
      report("range_start", {1'b0, word[64:2]}, {1'b0, want.lo});
    end
    if (word[127:65] !== want.hi) begin
      report("range_end", {1'b0, word[127:65]}, {1'b0, want.hi});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg = -64'sd1;
      clear_state();
      range_q.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        size_reg = cfg_wr_data;
      end
      if (out_tvalid && out_tready) begin
        check_word(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_END) begin
          range_q.push_back(resolve_range());
          clear_state();
        end else begin
          fold_char(in_tdata);
        end
      end
      pending <= range_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_http_byte_range_parser_top.sv =====
`timescale 1ns / 1ps
module tb_http_byte_range_parser_top;
  import hbrp_pkg::*;

  localparam logic [62:0] POS_MAX  = '1;
  localparam logic [7:0]  CH_COMMA = 8'h2c;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [SIZE_BITS-1:0] cfg_wr_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // header_byte
  logic                 in_tuser;   // command
  logic                 out_tvalid;
  logic                 out_tready;
  logic [127:0]         out_tdata;  // range_status, range_start, range_end
  int                   fail_count;
  int                   pending;

  logic               quiet;
  logic signed [63:0] cur_size;
  logic [7:0]         hdr[$];
  int                 sent;

  always #6 clk = ~clk;

  http_byte_range_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hbrp_range_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task send_word(input logic cmd, input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  task send_header();
    foreach (hdr[i]) begin
      send_word(CMD_BYTE, hdr[i]);
    end
    send_word(CMD_END, 8'($urandom_range(0, 255)));
    sent = sent + hdr.size() + 1;
  endtask

  // let the last result drain and the pipe settle before touching the register
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_size(input logic [63:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_size = v;
  endtask

  function void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      hdr.push_back(s[i]);
    end
  endfunction

  task run_text(input string s);
    hdr.delete();
    push_text(s);
    send_header();
  endtask

  function void push_ws();
    int w;
    w = $urandom_range(0, 5);
    hdr.push_back(w == 0 ? CH_SPACE : 8'h08 + w[7:0]);
  endfunction

  // positions biased toward the edges of the current size
  function logic [62:0] pick_pos();
    logic [63:0] r;
    int          off;
    off = $urandom_range(0, 4);
    r   = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return 63'($urandom_range(0, 20));
      1: begin
        if (cur_size < 2) begin
          return 63'(off);
        end else if (cur_size >= {1'b0, POS_MAX} - 2) begin
          return POS_MAX - 63'(off);
        end
        return 63'(cur_size - 2 + off);
      end
      2: return (cur_size > 0) ? 63'(r % cur_size) : 63'(r[5:0]);
      3: return r[62:0];
      4: return POS_MAX;
      default: return 63'($urandom_range(0, 1000));
    endcase
  endfunction

  function void push_pos();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(19, 24)) hdr.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      if ($urandom_range(0, 5) == 0) begin
        push_text("00");
      end
      push_text($sformatf("%0d", pick_pos()));
    end
  endfunction

  function void build_random();
    int kind;
    int form;
    int idx;
    logic [7:0] b;
    kind  = $urandom_range(0, 19);
    quiet = ($urandom_range(0, 4) == 0);
    hdr.delete();
    if (kind == 0) begin
      repeat ($urandom_range(0, 10)) hdr.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) push_ws();
    push_text("bytes=");
    form = $urandom_range(0, 3);
    if (form != 2) begin
      push_pos();
    end
    hdr.push_back(CH_DASH);
    if (form != 1) begin
      push_pos();
    end
    repeat ($urandom_range(0, 2)) push_ws();
    if (kind <= 5) begin
      idx = $urandom_range(0, hdr.size() - 1);
      case ($urandom_range(0, 3))
        0: hdr[idx] = 8'($urandom_range(0, 255));
        1: begin
          case ($urandom_range(0, 3))
            0:       b = CH_COMMA;
            1:       b = CH_SPACE;
            2:       b = CH_DASH;
            default: b = 8'($urandom_range(0, 255));
          endcase
          hdr.insert(idx, b);
        end
        2: hdr.delete(idx);
        default: begin
          while (hdr.size() > idx) hdr.delete(hdr.size() - 1);
        end
      endcase
    end
  endfunction

  function logic [63:0] phase_size(input int ph);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (ph)
      0: return {1'b0, POS_MAX};
      1: return 64'd1;
      2: return 64'd0;
      3: return 64'($urandom_range(2, 5000));
      4: return r;
      5: return 64'h8000_0000_0000_0000;
      6: return '1;
      7: return {1'b0, r[62:0]};
      default: return {32'd0, r[31:0]};
    endcase
  endfunction

  initial begin
    out_tready = 1'b0;
    forever begin
      int n;
      n = quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int ph;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_BYTE;
    quiet       = 1'b0;
    cur_size    = -64'sd1;
    sent        = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size unknown after reset
    run_text("bytes=0-1");
    drain();
    write_size(64'd0);
    run_text("bytes=-1");
    run_text("bytes=0-");
    drain();
    write_size(64'd1000);
    run_text("bytes=0-499");
    run_text("bytes=-200");
    run_text("bytes=-0");
    run_text("bytes=-5000");
    run_text("bytes=900-");
    run_text("bytes=1000-");
    run_text("bytes=5-2");
    run_text("bytes=0-99999");
    run_text("bytes=0-1,2-3");
    run_text("bytes=-");
    run_text("bytes=5");
    run_text("");
    run_text(" \t bytes=1-2 \r\n");
    run_text("bytes= 1-2");
    run_text("bytes=1--2");
    run_text("bytes=1-2 x");
    run_text("bytes=99999999999999999999999-");
    run_text("Bytes=1-2");
    hdr.delete();
    push_text("bytes=1-");
    hdr.push_back(8'hff);
    send_header();

    for (ph = 0; ph < 9; ph++) begin
      drain();
      write_size(phase_size(ph));
      sent = 0;
      while (sent < 80) begin
        build_random();
        send_header();
      end
    end

    quiet = 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
